>>> src/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants of the bilinear texture sampler
// Work item layout between front and back, result layout, queue sizes,
// configuration register indexes and the request opcodes.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int TEXEL_DEPTH_DFLT = 65536;

    localparam int IDX_W    = 16;
    localparam int IDX_SPAN = 1 << IDX_W;
    localparam int TEXEL_W  = 24;
    localparam int SIZE_W   = 9;
    localparam int COORD_W  = 18;
    localparam int WT_W     = 17;
    localparam int OUT_W    = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
    localparam logic [WT_W-1:0]   WT_ONE     = WT_W'(65536);

    // work queue between front and back
    localparam int Q_DEPTH = 8;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [Q_CNT_W:0] Q_LIMIT = (Q_CNT_W + 1)'(Q_DEPTH);

    // result buffer at the output
    localparam int OUT_DEPTH = 8;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
    localparam logic [OUT_CNT_W:0] OUT_LIMIT = (OUT_CNT_W + 1)'(OUT_DEPTH);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    // one classified request; a load uses idx_a and rgb only
    typedef struct packed {
        logic                 is_sample;
        logic [IDX_W-1:0]     idx_a;
        logic [IDX_W-1:0]     idx_b;
        logic [IDX_W-1:0]     idx_c;
        logic [IDX_W-1:0]     idx_d;
        logic [WT_W-1:0]      wt_a;
        logic [WT_W-1:0]      wt_b;
        logic [WT_W-1:0]      wt_c;
        logic [WT_W-1:0]      wt_d;
        logic [TEXEL_W-1:0]   rgb;
    } t_work;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } t_result;

endpackage

>>> src/bts_ram.sv
// ----------------------------------------------------------------------------
// bts_ram: generic RAM, one write port, two read ports
// Read data is registered; contents are not reset.
// ----------------------------------------------------------------------------
module bts_ram #(
    parameter  int WIDTH = 24,
    parameter  int DEPTH = 65536,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> src/bts_fifo.sv
// ----------------------------------------------------------------------------
// bts_fifo: small register FIFO
// Head is shown combinationally; the user never pushes when full nor pops
// when empty.
// ----------------------------------------------------------------------------
module bts_fifo #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 8,
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic [CW-1:0]    o_count
);

    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

>>> src/bts_front.sv
// ----------------------------------------------------------------------------
// bts_front: request intake and classification
// Holds the size registers, clamps u,v, scales them to texel coordinates
// and fractions, and forms the four store indexes and bilinear weights.
// Three stages, then the work queue. Out-of-range loads are dropped here.
// ----------------------------------------------------------------------------
module bts_front
    import bts_pkg::*;
#(
    parameter int TEXEL_DEPTH = TEXEL_DEPTH_DFLT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [SIZE_W-1:0]         i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [0:0]                i_opcode,
    input  logic [IDX_W-1:0]          i_texel_index,
    input  logic [7:0]                i_red_in,
    input  logic [7:0]                i_green_in,
    input  logic [7:0]                i_blue_in,
    input  logic signed [COORD_W-1:0] i_u_coord,
    input  logic signed [COORD_W-1:0] i_v_coord,
    input  logic [Q_CNT_W-1:0]        i_q_count,
    output logic                      o_push,
    output t_work                     o_entry
);

    localparam logic [20:0] DEPTH_V = 21'(TEXEL_DEPTH);

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
        if (s == '0) begin
            return SIZE_W'(1);
        end else if (s > SIZE_RESET) begin
            return SIZE_RESET;
        end
        return s;
    endfunction

    function automatic logic [WT_W-1:0] clamp_coord(input logic signed [COORD_W-1:0] c);
        if (c[COORD_W-1]) begin
            return '0;
        end else if (c[WT_W-1:0] > WT_ONE) begin
            return WT_ONE;
        end
        return c[WT_W-1:0];
    endfunction

    logic [SIZE_W-1:0] r_tex_width;
    logic [SIZE_W-1:0] r_tex_height;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic [7:0]        w_m1;
    logic [7:0]        h_m1;

    logic              accept;
    logic              is_sample;
    logic              n_f1_vld;
    logic [1:0]        inflight;

    // stage 1: clamped coordinates
    logic              r_f1_vld;
    logic              r_f1_sample;
    logic [IDX_W-1:0]  r_f1_idx;
    logic [TEXEL_W-1:0] r_f1_rgb;
    logic [WT_W-1:0]   r_f1_u;
    logic [WT_W-1:0]   r_f1_v;

    // stage 2: integer coordinate and fraction
    logic [24:0]       pos_x;
    logic [24:0]       pos_y;
    logic              r_f2_vld;
    logic              r_f2_sample;
    logic [IDX_W-1:0]  r_f2_idx;
    logic [TEXEL_W-1:0] r_f2_rgb;
    logic [7:0]        r_f2_xi;
    logic [7:0]        r_f2_yi;
    logic [7:0]        r_f2_s;
    logic [7:0]        r_f2_t;

    // stage 3: row bases and weights
    logic [7:0]        n_xn;
    logic [7:0]        n_yn;
    logic [8:0]        s_c;
    logic [8:0]        t_c;
    logic [16:0]       base_i_prod;
    logic [16:0]       base_n_prod;
    logic              r_f3_vld;
    logic              r_f3_sample;
    logic [IDX_W-1:0]  r_f3_idx;
    logic [TEXEL_W-1:0] r_f3_rgb;
    logic [IDX_W-1:0]  r_f3_base_i;
    logic [IDX_W-1:0]  r_f3_base_n;
    logic [7:0]        r_f3_xi;
    logic [7:0]        r_f3_xn;
    logic [WT_W-1:0]   r_f3_wt_a;
    logic [WT_W-1:0]   r_f3_wt_b;
    logic [WT_W-1:0]   r_f3_wt_c;
    logic [WT_W-1:0]   r_f3_wt_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= SIZE_RESET;
            r_tex_height <= SIZE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TEX_WIDTH) begin
                r_tex_width <= i_cfg_data;
            end else if (i_cfg_index == CFG_TEX_HEIGHT) begin
                r_tex_height <= i_cfg_data;
            end
        end
    end

    assign w_eff = clamp_size(r_tex_width);
    assign h_eff = clamp_size(r_tex_height);
    assign w_m1  = 8'(w_eff - SIZE_W'(1));
    assign h_m1  = 8'(h_eff - SIZE_W'(1));

    // reserve a queue slot for every request inside the front stages
    assign inflight  = 2'(r_f1_vld) + 2'(r_f2_vld) + 2'(r_f3_vld);
    assign o_stall   = ({1'b0, i_q_count} + (Q_CNT_W + 1)'(inflight)) >= Q_LIMIT;
    assign accept    = i_valid && !o_stall;
    assign is_sample = (i_opcode == OP_SAMPLE);
    assign n_f1_vld  = accept && (is_sample || ({5'd0, i_texel_index} < DEPTH_V));

    assign pos_x = 25'(r_f1_u) * 25'(w_m1);
    assign pos_y = 25'(r_f1_v) * 25'(h_m1);

    // step to the next column or row only for a nonzero fraction
    assign n_xn = (r_f2_s != 8'd0) ? r_f2_xi + 8'd1 : r_f2_xi;
    assign n_yn = (r_f2_t != 8'd0) ? r_f2_yi + 8'd1 : r_f2_yi;
    assign s_c  = 9'd256 - {1'b0, r_f2_s};
    assign t_c  = 9'd256 - {1'b0, r_f2_t};
    assign base_i_prod = 17'(w_eff) * 17'(r_f2_yi);
    assign base_n_prod = 17'(w_eff) * 17'(n_yn);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
        end else begin
            r_f1_vld <= n_f1_vld;
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_sample <= is_sample;
        r_f1_idx    <= i_texel_index;
        r_f1_rgb    <= {i_red_in, i_green_in, i_blue_in};
        r_f1_u      <= clamp_coord(i_u_coord);
        r_f1_v      <= clamp_coord(i_v_coord);

        r_f2_sample <= r_f1_sample;
        r_f2_idx    <= r_f1_idx;
        r_f2_rgb    <= r_f1_rgb;
        r_f2_xi     <= pos_x[23:16];
        r_f2_s      <= pos_x[15:8];
        r_f2_yi     <= pos_y[23:16];
        r_f2_t      <= pos_y[15:8];

        r_f3_sample <= r_f2_sample;
        r_f3_idx    <= r_f2_idx;
        r_f3_rgb    <= r_f2_rgb;
        r_f3_base_i <= base_i_prod[IDX_W-1:0];
        r_f3_base_n <= base_n_prod[IDX_W-1:0];
        r_f3_xi     <= r_f2_xi;
        r_f3_xn     <= n_xn;
        r_f3_wt_a   <= WT_W'(18'(s_c) * 18'(t_c));
        r_f3_wt_b   <= WT_W'(18'(r_f2_s) * 18'(t_c));
        r_f3_wt_c   <= WT_W'(18'(r_f2_s) * 18'(r_f2_t));
        r_f3_wt_d   <= WT_W'(18'(s_c) * 18'(r_f2_t));
    end

    always_comb begin
        o_entry           = '0;
        o_entry.is_sample = r_f3_sample;
        o_entry.idx_a     = r_f3_sample ? r_f3_base_i + IDX_W'(r_f3_xi) : r_f3_idx;
        o_entry.idx_b     = r_f3_base_i + IDX_W'(r_f3_xn);
        o_entry.idx_c     = r_f3_base_n + IDX_W'(r_f3_xn);
        o_entry.idx_d     = r_f3_base_n + IDX_W'(r_f3_xi);
        o_entry.wt_a      = r_f3_wt_a;
        o_entry.wt_b      = r_f3_wt_b;
        o_entry.wt_c      = r_f3_wt_c;
        o_entry.wt_d      = r_f3_wt_d;
        o_entry.rgb       = r_f3_rgb;
    end

    assign o_push = r_f3_vld;

`ifndef SYNTHESIS
    a_sample_reaches_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_opcode == OP_SAMPLE) |-> ##3 o_push)
        else $error("accepted sample did not reach the work queue");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> ({1'b0, i_q_count} < Q_LIMIT))
        else $error("work queue push without a free slot");

    a_weights_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.is_sample) |->
        ((19'(o_entry.wt_a) + 19'(o_entry.wt_b) + 19'(o_entry.wt_c)
          + 19'(o_entry.wt_d)) == 19'(WT_ONE)))
        else $error("bilinear weights do not sum to one");
`endif

endmodule

>>> src/bts_back.sv
// ----------------------------------------------------------------------------
// bts_back: texel store access and bilinear blend
// Wraps the four indexes into the store, writes loads, reads four texels
// per cycle from two replicated dual-read RAMs and blends per channel.
// Issues a sample only when a slot in the result buffer is reserved.
// ----------------------------------------------------------------------------
module bts_back
    import bts_pkg::*;
#(
    parameter int TEXEL_DEPTH = TEXEL_DEPTH_DFLT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  t_work                i_q_head,
    output logic                 o_q_pop,
    input  logic [OUT_CNT_W-1:0] i_out_count,
    output logic                 o_out_push,
    output t_result              o_out_data
);

    localparam int AW = $clog2(TEXEL_DEPTH);

    logic [2:0]         inflight;
    logic               credit_ok;

    // stage 1: popped request
    logic               r_b1_vld;
    t_work              r_b1;
    logic [IDX_W-1:0]   b1_idx [4];
    logic [WT_W-1:0]    b1_wt  [4];

    // stage 2: quotient for the wrap
    logic               r_b2_vld;
    logic               r_b2_sample;
    logic [IDX_W-1:0]   r_b2_idx [4];
    logic [WT_W-1:0]    r_b2_wt  [4];
    logic [TEXEL_W-1:0] r_b2_rgb;

    // stage 3: store addresses
    logic [AW-1:0]      n_b3_addr [4];
    logic               r_b3_vld;
    logic               r_b3_sample;
    logic [AW-1:0]      r_b3_addr [4];
    logic [WT_W-1:0]    r_b3_wt   [4];
    logic [TEXEL_W-1:0] r_b3_rgb;
    logic               ram_we;

    // stage 4: texels from the RAMs
    logic               r_b4_vld;
    logic [WT_W-1:0]    r_b4_wt [4];
    logic [TEXEL_W-1:0] texel   [4];
    logic [24:0]        n_b5_prod [3][4];

    // stage 5: weighted channel terms
    logic               r_b5_vld;
    logic [24:0]        r_b5_prod [3][4];
    logic [25:0]        chan_sum  [3];

    assign inflight = 3'(r_b1_vld & r_b1.is_sample) + 3'(r_b2_vld & r_b2_sample)
                    + 3'(r_b3_vld & r_b3_sample) + 3'(r_b4_vld) + 3'(r_b5_vld);
    assign credit_ok = ({1'b0, i_out_count} + (OUT_CNT_W + 1)'(inflight)) < OUT_LIMIT;
    assign o_q_pop   = !i_q_empty && (!i_q_head.is_sample || credit_ok);

    assign b1_idx[0] = r_b1.idx_a;
    assign b1_idx[1] = r_b1.idx_b;
    assign b1_idx[2] = r_b1.idx_c;
    assign b1_idx[3] = r_b1.idx_d;
    assign b1_wt[0]  = r_b1.wt_a;
    assign b1_wt[1]  = r_b1.wt_b;
    assign b1_wt[2]  = r_b1.wt_c;
    assign b1_wt[3]  = r_b1.wt_d;

    if (TEXEL_DEPTH < IDX_SPAN) begin : g_wrap
        // index mod depth: quotient by reciprocal, exact for 16-bit indexes
        localparam logic [63:0] RECIP64 =
            ((64'd1 << 32) + 64'(TEXEL_DEPTH) - 64'd1) / 64'(TEXEL_DEPTH);
        localparam logic [31:0] RECIP = RECIP64[31:0];
        localparam logic [IDX_W-1:0] DIV = IDX_W'(TEXEL_DEPTH);

        logic [47:0]      quot_prod [4];
        logic [IDX_W-1:0] r_b2_quot [4];
        logic [31:0]      back_prod [4];
        logic [IDX_W-1:0] rem       [4];

        for (genvar k = 0; k < 4; k++) begin : g_lane
            assign quot_prod[k] = 48'(b1_idx[k]) * 48'(RECIP);
            assign back_prod[k] = 32'(r_b2_quot[k]) * 32'(DIV);
            assign rem[k]       = r_b2_idx[k] - back_prod[k][IDX_W-1:0];
            assign n_b3_addr[k] = rem[k][AW-1:0];
        end

        always_ff @(posedge i_clk) begin
            for (int k = 0; k < 4; k++) begin
                r_b2_quot[k] <= quot_prod[k][47:32];
            end
        end
    end else begin : g_nowrap
        for (genvar k = 0; k < 4; k++) begin : g_lane
            assign n_b3_addr[k] = AW'(r_b2_idx[k]);
        end
    end

    assign ram_we = r_b3_vld && !r_b3_sample;

    bts_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (TEXEL_DEPTH)
    ) u_ram_ab (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_b3_addr[0]),
        .i_wdata   (r_b3_rgb),
        .i_raddr_a (r_b3_addr[0]),
        .i_raddr_b (r_b3_addr[1]),
        .o_rdata_a (texel[0]),
        .o_rdata_b (texel[1])
    );

    bts_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (TEXEL_DEPTH)
    ) u_ram_cd (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_b3_addr[0]),
        .i_wdata   (r_b3_rgb),
        .i_raddr_a (r_b3_addr[2]),
        .i_raddr_b (r_b3_addr[3]),
        .o_rdata_a (texel[2]),
        .o_rdata_b (texel[3])
    );

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int c = 0; c < 4; c++) begin
                n_b5_prod[ch][c] = 25'(r_b4_wt[c]) * 25'(texel[c][23 - 8 * ch -: 8]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_b3_vld <= 1'b0;
            r_b4_vld <= 1'b0;
            r_b5_vld <= 1'b0;
        end else begin
            r_b1_vld <= o_q_pop;
            r_b2_vld <= r_b1_vld;
            r_b3_vld <= r_b2_vld;
            // loads end at the store write
            r_b4_vld <= r_b3_vld && r_b3_sample;
            r_b5_vld <= r_b4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1        <= i_q_head;
        r_b2_sample <= r_b1.is_sample;
        r_b2_rgb    <= r_b1.rgb;
        r_b3_sample <= r_b2_sample;
        r_b3_rgb    <= r_b2_rgb;
        for (int k = 0; k < 4; k++) begin
            r_b2_idx[k]  <= b1_idx[k];
            r_b2_wt[k]   <= b1_wt[k];
            r_b3_addr[k] <= n_b3_addr[k];
            r_b3_wt[k]   <= r_b2_wt[k];
            r_b4_wt[k]   <= r_b3_wt[k];
        end
        r_b5_prod <= n_b5_prod;
    end

    // round half up, keep 8 fraction bits
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            chan_sum[ch] = 26'(r_b5_prod[ch][0]) + 26'(r_b5_prod[ch][1])
                         + 26'(r_b5_prod[ch][2]) + 26'(r_b5_prod[ch][3]) + 26'd128;
        end
    end

    assign o_out_push       = r_b5_vld;
    assign o_out_data.red   = chan_sum[0][23:8];
    assign o_out_data.green = chan_sum[1][23:8];
    assign o_out_data.blue  = chan_sum[2][23:8];

`ifndef SYNTHESIS
    a_sample_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_head.is_sample) |-> ##5 o_out_push)
        else $error("issued sample did not reach the result buffer");

    a_result_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, i_out_count} + (OUT_CNT_W + 1)'(inflight)) <= OUT_LIMIT)
        else $error("samples in flight exceed result buffer room");
`endif

endmodule

>>> src/bilinear_texture_sampler_top.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_top: RGB texture store with bilinear sampling
// In-range load requests write one texel; sample requests return one filtered RGB
// result with 8 fraction bits per channel.
//
//   channel   handshake               payload
//   request   i_valid / o_stall       i_opcode, i_texel_index, i_red_in,
//                                     i_green_in, i_blue_in, i_u_coord,
//                                     i_v_coord
//   result    o_valid / i_stall       o_red_out, o_green_out, o_blue_out
//   config    i_cfg_we                i_cfg_index, i_cfg_data
//
// One request per cycle sustained while o_stall is low; the four neighbour
// reads each cycle come from two replicated texel RAMs, two read ports each.
// A sample goes through front, work queue and back into the result buffer.
// Reset sets both size registers to 256; the texel store is not cleared and
// needs no sweep, so requests are taken right after reset.
// o_stall rises when the 8-entry work queue is spoken for; the back end
// issues a sample only with a slot held in the 8-entry result buffer.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_top
    import bts_pkg::*;
#(
    parameter int TEXEL_DEPTH = TEXEL_DEPTH_DFLT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [SIZE_W-1:0]         i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [0:0]                i_opcode,
    input  logic [IDX_W-1:0]          i_texel_index,
    input  logic [7:0]                i_red_in,
    input  logic [7:0]                i_green_in,
    input  logic [7:0]                i_blue_in,
    input  logic signed [COORD_W-1:0] i_u_coord,
    input  logic signed [COORD_W-1:0] i_v_coord,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [OUT_W-1:0]          o_red_out,
    output logic [OUT_W-1:0]          o_green_out,
    output logic [OUT_W-1:0]          o_blue_out
);

    localparam int WORK_W   = $bits(t_work);
    localparam int RESULT_W = $bits(t_result);

    logic                 q_push;
    t_work                q_entry;
    logic [WORK_W-1:0]    q_rdata;
    t_work                q_head;
    logic                 q_pop;
    logic                 q_empty;
    logic [Q_CNT_W-1:0]   q_count;

    logic                 out_push;
    t_result              out_entry;
    logic [RESULT_W-1:0]  out_rdata;
    t_result              out_head;
    logic                 out_pop;
    logic                 out_empty;
    logic [OUT_CNT_W-1:0] out_count;

    bts_front #(
        .TEXEL_DEPTH (TEXEL_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_texel_index (i_texel_index),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_u_coord     (i_u_coord),
        .i_v_coord     (i_v_coord),
        .i_q_count     (q_count),
        .o_push        (q_push),
        .o_entry       (q_entry)
    );

    bts_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (Q_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (WORK_W'(q_entry)),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    assign q_head = t_work'(q_rdata);

    bts_back #(
        .TEXEL_DEPTH (TEXEL_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_data  (out_entry)
    );

    bts_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (OUT_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (RESULT_W'(out_entry)),
        .i_pop   (out_pop),
        .o_data  (out_rdata),
        .o_empty (out_empty),
        .o_count (out_count)
    );

    assign out_head    = t_result'(out_rdata);
    assign o_valid     = !out_empty;
    assign out_pop     = o_valid && !i_stall;
    assign o_red_out   = out_head.red;
    assign o_green_out = out_head.green;
    assign o_blue_out  = out_head.blue;

endmodule

>>> test/bilinear_texture_sampler_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_top_tb: self-checking bench for the texture sampler
// Loads texels and samples them across several texture sizes. A scoreboard
// keeps its own copy of the texel store and of the size registers, predicts
// every filtered RGB result and checks the results in order. Random gaps on
// both channels, one long result hold-off, and a watchdog on quiet cycles.
// ----------------------------------------------------------------------------
import bts_pkg::*;

class texture_scoreboard;
    logic [TEXEL_W-1:0] texel_copy [IDX_SPAN];
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    t_result            expected_rgb [$];
    int                 failures;

    function new();
        width_reg  = SIZE_RESET;
        height_reg = SIZE_RESET;
        failures   = 0;
    endfunction

    function void write_size(logic [CFG_IDX_W-1:0] index, logic [SIZE_W-1:0] value);
        case (index)
            CFG_TEX_WIDTH:  width_reg  = value;
            CFG_TEX_HEIGHT: height_reg = value;
            default: ;
        endcase
    endfunction

    static function int unsigned used_size(logic [SIZE_W-1:0] size);
        if (size == 0) return 1;
        if (size > 256) return 256;
        return 32'(size);
    endfunction

    static function int unsigned clamp_q16(logic signed [COORD_W-1:0] coord);
        if (coord < 0) return 0;
        if (coord > 65536) return 65536;
        return 32'(coord);
    endfunction

    static function int unsigned channel_byte(logic [TEXEL_W-1:0] texel, int k);
        return (32'(texel) >> (16 - 8 * k)) & 32'hFF;
    endfunction

    // Four neighbour indexes and their weights for one sample point.
    function t_work sample_taps(logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
        t_work       taps;
        int unsigned w, h, px, py, xi, yi, xn, yn, s, t;
        w  = used_size(width_reg);
        h  = used_size(height_reg);
        px = clamp_q16(u) * (w - 1);
        py = clamp_q16(v) * (h - 1);
        xi = px >> 16;
        yi = py >> 16;
        s  = (px >> 8) & 32'hFF;
        t  = (py >> 8) & 32'hFF;
        // reuse the same column or row when the fraction is zero
        xn = (s != 0) ? xi + 1 : xi;
        yn = (t != 0) ? yi + 1 : yi;
        taps           = '0;
        taps.is_sample = 1'b1;
        taps.idx_a     = IDX_W'(w * yi + xi);
        taps.idx_b     = IDX_W'(w * yi + xn);
        taps.idx_c     = IDX_W'(w * yn + xn);
        taps.idx_d     = IDX_W'(w * yn + xi);
        taps.wt_a      = WT_W'((256 - s) * (256 - t));
        taps.wt_b      = WT_W'(s * (256 - t));
        taps.wt_c      = WT_W'(s * t);
        taps.wt_d      = WT_W'((256 - s) * t);
        return taps;
    endfunction

    function void note_request(t_op op, logic [IDX_W-1:0] index, logic [TEXEL_W-1:0] rgb,
                               logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
        t_work            taps;
        int unsigned      sum;
        logic [OUT_W-1:0] blended [3];
        t_result          want;
        if (op == OP_LOAD) begin
            texel_copy[index] = rgb;
        end else begin
            taps = sample_taps(u, v);
            for (int k = 0; k < 3; k++) begin
                sum = taps.wt_a * channel_byte(texel_copy[taps.idx_a], k)
                    + taps.wt_b * channel_byte(texel_copy[taps.idx_b], k)
                    + taps.wt_c * channel_byte(texel_copy[taps.idx_c], k)
                    + taps.wt_d * channel_byte(texel_copy[taps.idx_d], k);
                blended[k] = OUT_W'((sum + 128) >> 8);
            end
            want.red   = blended[0];
            want.green = blended[1];
            want.blue  = blended[2];
            expected_rgb.push_back(want);
        end
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (expected_rgb.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("%0t: result with none expected: r=%h g=%h b=%h",
                         $realtime, got.red, got.green, got.blue);
            return;
        end
        want = expected_rgb.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            failures++;
            if (failures <= 10)
                $display("%0t: mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                         $realtime, want.red, want.green, want.blue,
                         got.red, got.green, got.blue);
        end
    endfunction

    function int pending();
        return expected_rgb.size();
    endfunction
endclass

module bilinear_texture_sampler_top_tb;

    localparam int GAP_MAX         = 13;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASE_ITEMS     = 72;

    localparam logic signed [COORD_W-1:0] COORD_ZERO = '0;
    localparam logic signed [COORD_W-1:0] COORD_ONE  = COORD_W'(65536);
    localparam logic signed [COORD_W-1:0] COORD_HALF = COORD_W'(32768);
    localparam logic signed [COORD_W-1:0] COORD_MAX  = COORD_W'(131071);
    localparam logic signed [COORD_W-1:0] COORD_MIN  = COORD_W'(-131072);

    // indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    typedef struct packed {
        t_op                       op;
        logic [IDX_W-1:0]          index;
        logic [TEXEL_W-1:0]        rgb;
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
    } t_request;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [SIZE_W-1:0]         i_cfg_data;
    logic                      i_valid;
    logic                      o_stall;
    logic [0:0]                i_opcode;
    logic [IDX_W-1:0]          i_texel_index;
    logic [7:0]                i_red_in;
    logic [7:0]                i_green_in;
    logic [7:0]                i_blue_in;
    logic signed [COORD_W-1:0] i_u_coord;
    logic signed [COORD_W-1:0] i_v_coord;
    logic                      o_valid;
    logic                      i_stall;
    logic [OUT_W-1:0]          o_red_out;
    logic [OUT_W-1:0]          o_green_out;
    logic [OUT_W-1:0]          o_blue_out;

    texture_scoreboard sb = new();

    bit texel_loaded [IDX_SPAN];
    int items_sent       = 0;
    int quiet_cycles     = 0;
    bit sender_calm      = 1'b0;
    bit receiver_calm    = 1'b0;
    bit burst_mode       = 1'b0;
    bit hold_off_pending = 1'b0;

    bilinear_texture_sampler_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_texel_index (i_texel_index),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_u_coord     (i_u_coord),
        .i_v_coord     (i_v_coord),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin : handshake_monitor
        t_result got;
        bit      fired;
        fired = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            sb.note_request(t_op'(i_opcode), i_texel_index, {i_red_in, i_green_in, i_blue_in},
                            i_u_coord, i_v_coord);
            fired = 1'b1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got.red   = o_red_out;
            got.green = o_green_out;
            got.blue  = o_blue_out;
            sb.check_result(got);
            fired = 1'b1;
        end
        quiet_cycles = fired ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(input t_request req);
        int gap;
        if ($urandom_range(0, 19) == 0) sender_calm = !sender_calm;
        gap = (sender_calm || burst_mode) ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= req.op;
        i_texel_index <= req.index;
        i_red_in      <= req.rgb[23:16];
        i_green_in    <= req.rgb[15:8];
        i_blue_in     <= req.rgb[7:0];
        i_u_coord     <= req.u;
        i_v_coord     <= req.v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic load_texel(input logic [IDX_W-1:0] index, input logic [TEXEL_W-1:0] rgb);
        t_request req;
        req.op    = OP_LOAD;
        req.index = index;
        req.rgb   = rgb;
        req.u     = COORD_W'($urandom);
        req.v     = COORD_W'($urandom);
        texel_loaded[index] = 1'b1;
        send_request(req);
    endtask

    // Load any neighbour never written so far, then sample.
    task automatic sample_at(input logic signed [COORD_W-1:0] u,
                             input logic signed [COORD_W-1:0] v);
        t_work            taps;
        logic [IDX_W-1:0] tap_idx [4];
        t_request         req;
        taps       = sb.sample_taps(u, v);
        tap_idx[0] = taps.idx_a;
        tap_idx[1] = taps.idx_b;
        tap_idx[2] = taps.idx_c;
        tap_idx[3] = taps.idx_d;
        foreach (tap_idx[n])
            if (!texel_loaded[tap_idx[n]]) load_texel(tap_idx[n], TEXEL_W'($urandom));
        req.op    = OP_SAMPLE;
        req.index = IDX_W'($urandom);
        req.rgb   = TEXEL_W'($urandom);
        req.u     = u;
        req.v     = v;
        send_request(req);
    endtask

    function automatic logic signed [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0: return COORD_W'($urandom);
            1: begin
                case ($urandom_range(0, 5))
                    0:       return COORD_ZERO;
                    1:       return COORD_ONE;
                    2:       return COORD_W'(-1);
                    3:       return COORD_ONE - COORD_W'(1);
                    4:       return COORD_MAX;
                    default: return COORD_MIN;
                endcase
            end
            default: return COORD_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic write_size_reg(input logic [CFG_IDX_W-1:0] index,
                                  input logic [SIZE_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_size(index, value);
    endtask

    // Drop valid, wait for every result, then let trailing loads finish.
    // Take a clock edge first so the last accepted request is already noted.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] width_val,
                             input logic [SIZE_W-1:0] height_val, input bit pressure);
        int unsigned region;
        int          stop_at;
        write_size_reg(CFG_TEX_WIDTH, width_val);
        write_size_reg(CFG_TEX_HEIGHT, height_val);
        region  = sb.used_size(width_val) * sb.used_size(height_val);
        stop_at = items_sent + PHASE_ITEMS;
        if (pressure) begin
            burst_mode       = 1'b1;
            hold_off_pending = 1'b1;
        end
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) begin
                // overwrite inside the texture or anywhere in the store
                if ($urandom_range(0, 1) == 0)
                    load_texel(IDX_W'($urandom_range(0, region - 1)), TEXEL_W'($urandom));
                else
                    load_texel(IDX_W'($urandom), TEXEL_W'($urandom));
            end else begin
                sample_at(random_coord(), random_coord());
            end
        end
        burst_mode = 1'b0;
        drain();
    endtask

    initial begin : result_sink
        int gap;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_pending) begin
                // hold results back long enough for the block to fill up
                hold_off_pending = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            if ($urandom_range(0, 19) == 0) receiver_calm = !receiver_calm;
            gap = receiver_calm ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_opcode      <= OP_LOAD;
        i_texel_index <= '0;
        i_red_in      <= '0;
        i_green_in    <= '0;
        i_blue_in     <= '0;
        i_u_coord     <= '0;
        i_v_coord     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset sizes of 256 by 256
        load_texel(IDX_W'(0), 24'h000000);
        load_texel(IDX_W'(IDX_SPAN - 1), 24'hFFFFFF);
        load_texel(16'hAAAA, 24'hAA55AA);
        load_texel(16'h5555, 24'h55AA55);
        sample_at(COORD_ZERO, COORD_ZERO);
        sample_at(COORD_ONE, COORD_ONE);
        sample_at(COORD_MIN, COORD_MAX);
        sample_at(COORD_MAX, COORD_W'(-1));
        sample_at(COORD_ONE - COORD_W'(1), COORD_ONE - COORD_W'(1));
        sample_at(COORD_HALF, COORD_HALF);
        sample_at(COORD_W'(257), COORD_W'(1));
        sample_at(COORD_ONE + COORD_W'(1), -COORD_ONE);
        // sample a texel right after rewriting it
        load_texel(IDX_W'(0), 24'h123456);
        sample_at(COORD_ZERO, COORD_ZERO);
        drain();

        run_phase(SIZE_W'(1), SIZE_W'(1), 1'b0);
        run_phase(SIZE_W'(0), SIZE_W'(0), 1'b0);
        write_size_reg(CFG_SPARE_LO, SIZE_W'($urandom));
        write_size_reg(CFG_SPARE_HI, SIZE_W'($urandom));
        run_phase(SIZE_W'(511), SIZE_W'(300), 1'b0);
        run_phase(SIZE_W'(2), SIZE_W'(2), 1'b0);
        run_phase(SIZE_W'(3), SIZE_W'(7), 1'b1);
        run_phase(SIZE_W'(256), SIZE_W'(1), 1'b0);
        run_phase(SIZE_W'(1), SIZE_W'(256), 1'b0);
        run_phase(SIZE_W'(256), SIZE_W'(256), 1'b0);
        run_phase(SIZE_W'($urandom_range(1, 16)), SIZE_W'($urandom_range(1, 16)), 1'b0);
        run_phase(SIZE_W'($urandom_range(0, 511)), SIZE_W'($urandom_range(0, 511)), 1'b0);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
src/bts_pkg.sv
src/bts_ram.sv
src/bts_fifo.sv
src/bts_front.sv
src/bts_back.sv
src/bilinear_texture_sampler_top.sv
test/bilinear_texture_sampler_top_tb.sv
